### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the consequent checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sld_pkg.sv
// ---------------------------------------------------------------------------
// sld_pkg
// Types and constants of the sync, length and XOR word deframer.
// ---------------------------------------------------------------------------
package sld_pkg;

	localparam int WORD_W = 32;
	localparam int LEN_W = 16;
	localparam int CNT_W = LEN_W + 1;
	localparam int IDX_W = 1;

	localparam logic [WORD_W-1:0] SYNC_TAG_RESET = 32'h1bdf9bdf;
	localparam logic [LEN_W-1:0] TIMEOUT_RESET = 16'd2;
	localparam logic [WORD_W-1:0] LEN_MASK = 32'h0000ffff;
	localparam logic [LEN_W-1:0] TICK_MAX = 16'hffff;

	localparam logic [IDX_W-1:0] REG_SYNC_TAG = 1'b0;
	localparam logic [IDX_W-1:0] REG_TIMEOUT_LIMIT = 1'b1;

	localparam logic OP_WORD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	localparam logic [1:0] KIND_SYNC = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_CHECKSUM = 2'd3;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_OK = 2'd1;
	localparam logic [1:0] ST_BAD_SUM = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] sync_tag;
		logic [LEN_W-1:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [1:0] kind;
		logic last;
		logic [1:0] status;
	} result_t;

endpackage

### hdl/sync_length_xor_word_deframer_unit.sv
// ---------------------------------------------------------------------------
// sync_length_xor_word_deframer_unit
// Hunts for a sync word, frames header, payload and checksum words by length,
// and checks that the XOR of all frame words is zero.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------
//  input    | in_valid / in_ready     | op, word_in
//  output   | out_valid / out_ready   | word_out, kind, last, status
//  config   | cfg_wen                 | cfg_idx, cfg_data
//
//  One beat is taken every cycle unless the output stalls; an accepted beat
//  passes through the input register and then the result register, and the
//  frame state updates between the two. Ticks and dropped words give no output
//  beat. While the output stalls, one more input beat is held in the input
//  register. Reset clears the frame state and loads the register defaults.
// ---------------------------------------------------------------------------
module sync_length_xor_word_deframer_unit import sld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [WORD_W-1:0] word_in,
	output logic out_valid,
	input logic out_ready,
	output logic [WORD_W-1:0] word_out,
	output logic [1:0] kind,
	output logic last,
	output logic [1:0] status,
	input logic cfg_wen,
	input logic [IDX_W-1:0] cfg_idx,
	input logic [WORD_W-1:0] cfg_data
);

	cfg_t cfg;
	logic v_s1;
	logic op_s1;
	logic [WORD_W-1:0] word_s1;
	logic emit;
	result_t res;
	logic out_free;
	logic adv;
	logic out_valid_q;
	result_t res_q;

	sld_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	sld_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.op(op_s1),
		.word(word_s1),
		.cfg(cfg),
		.emit(emit),
		.res(res)
	);

	assign out_free = !out_valid_q || out_ready;
	assign adv = v_s1 && (!emit || out_free);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op;
			word_s1 <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign word_out = res_q.word;
	assign kind = res_q.kind;
	assign last = res_q.last;
	assign status = res_q.status;

endmodule

### hdl/sld_cfg.sv
// ---------------------------------------------------------------------------
// sld_cfg
// Configuration registers: sync tag and timeout limit.
// ---------------------------------------------------------------------------
module sld_cfg import sld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [IDX_W-1:0] cfg_idx,
	input logic [WORD_W-1:0] cfg_data,
	output cfg_t cfg
);

	logic [WORD_W-1:0] sync_tag_q;
	logic [LEN_W-1:0] timeout_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_tag_q <= SYNC_TAG_RESET;
			timeout_limit_q <= TIMEOUT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_SYNC_TAG: sync_tag_q <= cfg_data;
				REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.sync_tag = sync_tag_q;
	assign cfg.timeout_limit = timeout_limit_q;

endmodule

### hdl/sld_core.sv
// ---------------------------------------------------------------------------
// sld_core
// Frame state and the combinational decision for one received word or tick.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sld_core import sld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic op,
	input logic [WORD_W-1:0] word,
	input cfg_t cfg,
	output logic emit,
	output result_t res
);

	logic [1:0] phase_q, phase_n;
	logic [CNT_W-1:0] word_cnt_q, word_cnt_n;
	logic [LEN_W-1:0] frame_len_q, frame_len_n;
	logic [WORD_W-1:0] xor_q, xor_n;
	logic [LEN_W-1:0] tick_q, tick_n;
	logic [WORD_W-1:0] xor_x;
	logic more_payload;

	assign xor_x = xor_q ^ word;
	assign more_payload = ({1'b0, frame_len_q} + CNT_W'(2)) > word_cnt_q;

	always_comb begin
		phase_n = phase_q;
		word_cnt_n = word_cnt_q;
		frame_len_n = frame_len_q;
		xor_n = xor_q;
		tick_n = tick_q;
		emit = 1'b0;
		res = '0;
		if (op == OP_TICK) begin
			if (phase_q == PH_DATA && tick_q != TICK_MAX) begin
				tick_n = tick_q + LEN_W'(1);
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					tick_n = '0;
					if (word == cfg.sync_tag) begin
						word_cnt_n = CNT_W'(1);
						xor_n = word;
						phase_n = PH_HEADER;
						emit = 1'b1;
						res = '{word: word, kind: KIND_SYNC, last: 1'b0, status: ST_BUSY};
					end
				end
				PH_HEADER: begin
					frame_len_n = LEN_W'(word & LEN_MASK);
					xor_n = xor_x;
					word_cnt_n = CNT_W'(2);
					tick_n = '0;
					phase_n = PH_DATA;
					emit = 1'b1;
					res = '{word: word, kind: KIND_HEADER, last: 1'b0, status: ST_BUSY};
				end
				PH_DATA: begin
					emit = 1'b1;
					if (tick_q > cfg.timeout_limit) begin
						phase_n = PH_HUNT;
						word_cnt_n = '0;
						xor_n = '0;
						tick_n = '0;
						res = '{word: '0, kind: KIND_SYNC, last: 1'b1, status: ST_TIMEOUT};
					end else if (more_payload) begin
						xor_n = xor_x;
						word_cnt_n = word_cnt_q + CNT_W'(1);
						res = '{word: word, kind: KIND_PAYLOAD, last: 1'b0, status: ST_BUSY};
					end else begin
						phase_n = PH_HUNT;
						word_cnt_n = '0;
						xor_n = '0;
						tick_n = '0;
						res = '{word: word, kind: KIND_CHECKSUM, last: 1'b1,
							status: (xor_x == '0) ? ST_OK : ST_BAD_SUM};
					end
				end
				default: begin
					phase_n = PH_HUNT;
					word_cnt_n = '0;
					xor_n = '0;
					tick_n = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			word_cnt_q <= '0;
			frame_len_q <= '0;
			xor_q <= '0;
			tick_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			word_cnt_q <= word_cnt_n;
			frame_len_q <= frame_len_n;
			xor_q <= xor_n;
			tick_q <= tick_n;
		end
	end

	`ASSERT_NEXT(a_last_to_hunt, clk, arst_n, step && emit && res.last, phase_q == PH_HUNT,
		"frame end did not return to hunting")
	`ASSERT_SAME(a_count_bound, clk, arst_n, phase_q == PH_DATA,
		({1'b0, frame_len_q} + CNT_W'(2)) >= word_cnt_q, "word count ran past frame length")
	`ASSERT_SAME(a_tick_idle, clk, arst_n, phase_q != PH_DATA, tick_q == '0,
		"tick count not clear outside data phase")

endmodule
